>>> rtl/kwmh_pkg.sv
// Shared types and constants for the k-way min-heap merge core.
package kwmh_pkg;

   localparam int VALUE_W    = 32;
   localparam int LIST_W     = 4;
   localparam int COUNT_W    = 5;
   localparam int KEY_W      = VALUE_W + LIST_W;
   localparam int REQ_DATA_W = 40;
   localparam int RSP_DATA_W = 40;

   localparam logic [COUNT_W-1:0] LIST_COUNT_RESET = 5'd16;

   localparam logic OP_EXHAUSTED = 1'b1;
   localparam logic KIND_ELEMENT = 1'b0;
   localparam logic KIND_DONE    = 1'b1;

   typedef logic [KEY_W-1:0] key_type;

   typedef struct packed {
      logic                      kind;
      logic signed [VALUE_W-1:0] merged_value;
      logic [LIST_W-1:0]         source_list;
   } result_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_UP,
      ST_UP_ROOT,
      ST_DECIDE,
      ST_DONE,
      ST_POP,
      ST_DOWN,
      ST_DOWN_PLACE
   } state_type;

endpackage

>>> rtl/kwmh_heap_ram.sv
// Heap entry storage: one write port, two registered read ports.
module kwmh_heap_ram #(
   parameter int DEPTH = 16,
   parameter int AW    = 4
) (
   input  logic             clock,
   input  logic             we,
   input  logic [AW-1:0]    waddr,
   input  kwmh_pkg::key_type wdata,
   input  logic             re_a,
   input  logic [AW-1:0]    raddr_a,
   input  logic             re_b,
   input  logic [AW-1:0]    raddr_b,
   output kwmh_pkg::key_type rdata_a,
   output kwmh_pkg::key_type rdata_b
);
   import kwmh_pkg::*;

   key_type heap_mem [DEPTH];
   key_type rdata_a_ff;
   key_type rdata_b_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         heap_mem[waddr] <= wdata;
      end
      if (re_a) begin
         rdata_a_ff <= heap_mem[raddr_a];
      end
      if (re_b) begin
         rdata_b_ff <= heap_mem[raddr_b];
      end
   end

   assign rdata_a = rdata_a_ff;
   assign rdata_b = rdata_b_ff;

endmodule

>>> rtl/kwmh_sift_ctrl.sv
// Heap sequencer: push with sift-up, pop with sift-down, load and merge phases.
module kwmh_sift_ctrl #(
   parameter int MAX_LISTS = 16,
   parameter int IW        = 4,
   parameter int SW        = 5
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    in_valid,
   output logic                                    in_ready,
   input  logic                                    in_op,
   input  logic [kwmh_pkg::LIST_W-1:0]             in_list,
   input  logic signed [kwmh_pkg::VALUE_W-1:0]     in_value,
   input  logic [kwmh_pkg::COUNT_W-1:0]            list_count,
   output logic                                    res_valid,
   input  logic                                    res_ready,
   output kwmh_pkg::result_type                    res,
   output logic                                    mem_we,
   output logic [IW-1:0]                           mem_waddr,
   output kwmh_pkg::key_type                       mem_wdata,
   output logic                                    mem_re_a,
   output logic [IW-1:0]                           mem_raddr_a,
   output logic                                    mem_re_b,
   output logic [IW-1:0]                           mem_raddr_b,
   input  kwmh_pkg::key_type                       mem_rdata_a,
   input  kwmh_pkg::key_type                       mem_rdata_b
);
   import kwmh_pkg::*;

   localparam int CW = IW + 2;
   localparam int EW = (SW > COUNT_W) ? SW : COUNT_W;

   state_type            state_ff, state_in;
   logic [IW-1:0]        idx_ff, idx_in;
   logic [IW-1:0]        par_ff, par_in;
   key_type              key_ff, key_in;
   logic [SW-1:0]        size_ff, size_in;
   logic [COUNT_W-1:0]   loaded_ff, loaded_in;
   logic                 merging_ff, merging_in;

   key_type              new_key;
   logic                 can_push;
   logic [SW-1:0]        size_m1;
   logic [IW-1:0]        size_par;
   logic [IW-1:0]        par_m1;
   logic [IW-1:0]        par_of_par;
   logic                 up_stop;
   logic [CW-1:0]        size_ext;
   logic [CW-1:0]        l_cur, r_cur;
   logic                 sel_l, sel_r;
   key_type              best_l;
   logic [IW-1:0]        nidx;
   logic [CW-1:0]        nl, nr;
   logic                 down_more;
   logic                 pop_more;
   logic [COUNT_W-1:0]   loaded_inc;
   logic [EW-1:0]        eff;
   logic [EW-1:0]        lc_ext;
   logic                 emit;

   // Writes and reads never hit the same entry in one cycle: reads always go
   // to ancestors or descendants of the entry written, so no forwarding is needed.
   assign new_key    = {~in_value[VALUE_W-1], in_value[VALUE_W-2:0], in_list};
   assign can_push   = (in_op != OP_EXHAUSTED) && (size_ff < SW'(MAX_LISTS));
   assign size_m1    = size_ff - SW'(1);
   assign size_par   = size_m1[IW-1:0] >> 1;
   assign par_m1     = par_ff - IW'(1);
   assign par_of_par = par_m1 >> 1;
   assign up_stop    = mem_rdata_a <= key_ff;

   assign size_ext = CW'(size_ff);
   assign l_cur    = {1'b0, idx_ff, 1'b1};
   assign r_cur    = l_cur + CW'(1);
   assign sel_l    = (l_cur < size_ext) && (mem_rdata_a < key_ff);
   assign best_l   = sel_l ? mem_rdata_a : key_ff;
   assign sel_r    = (r_cur < size_ext) && (mem_rdata_b < best_l);
   assign nidx     = sel_r ? r_cur[IW-1:0] : l_cur[IW-1:0];
   assign nl       = {1'b0, nidx, 1'b1};
   assign nr       = nl + CW'(1);
   assign down_more = nl < size_ext;
   assign pop_more  = size_ff > SW'(2);

   assign loaded_inc = loaded_ff + COUNT_W'(1);
   assign lc_ext     = EW'(list_count);
   always_comb begin
      if (lc_ext == '0) begin
         eff = EW'(1);
      end else if (lc_ext > EW'(MAX_LISTS)) begin
         eff = EW'(MAX_LISTS);
      end else begin
         eff = lc_ext;
      end
   end
   assign emit = merging_ff || (EW'(loaded_inc) >= eff);

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (in_valid) begin
               state_in = (can_push && (size_ff != '0)) ? ST_UP : ST_DECIDE;
            end
         end
         ST_UP: begin
            if (up_stop) begin
               state_in = ST_DECIDE;
            end else if (par_ff == '0) begin
               state_in = ST_UP_ROOT;
            end
         end
         ST_UP_ROOT: state_in = ST_DECIDE;
         ST_DECIDE: begin
            if (!emit) begin
               state_in = ST_IDLE;
            end else if (size_ff == '0) begin
               state_in = ST_DONE;
            end else begin
               state_in = ST_POP;
            end
         end
         ST_DONE: begin
            if (res_ready) begin
               state_in = ST_IDLE;
            end
         end
         ST_POP: begin
            if (res_ready) begin
               state_in = pop_more ? ST_DOWN : ST_IDLE;
            end
         end
         ST_DOWN: begin
            if (!(sel_l || sel_r)) begin
               state_in = ST_IDLE;
            end else if (!down_more) begin
               state_in = ST_DOWN_PLACE;
            end
         end
         ST_DOWN_PLACE: state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      idx_in      = idx_ff;
      par_in      = par_ff;
      key_in      = key_ff;
      size_in     = size_ff;
      loaded_in   = loaded_ff;
      merging_in  = merging_ff;
      in_ready    = 1'b0;
      res_valid   = 1'b0;
      res         = '{kind: KIND_DONE, merged_value: '0, source_list: '0};
      mem_we      = 1'b0;
      mem_waddr   = idx_ff;
      mem_wdata   = key_ff;
      mem_re_a    = 1'b0;
      mem_raddr_a = '0;
      mem_re_b    = 1'b0;
      mem_raddr_b = '0;
      case (state_ff)
         ST_IDLE: begin
            in_ready = 1'b1;
            if (in_valid) begin
               key_in = new_key;
               if (can_push) begin
                  size_in = size_ff + SW'(1);
                  idx_in  = size_ff[IW-1:0];
                  par_in  = size_par;
                  if (size_ff == '0) begin
                     mem_we    = 1'b1;
                     mem_waddr = '0;
                     mem_wdata = new_key;
                  end else begin
                     mem_re_a    = 1'b1;
                     mem_raddr_a = size_par;
                  end
               end
            end
         end
         ST_UP: begin
            mem_we = 1'b1;
            if (up_stop) begin
               mem_wdata = key_ff;
            end else begin
               mem_wdata = mem_rdata_a;
               idx_in    = par_ff;
               if (par_ff != '0) begin
                  par_in      = par_of_par;
                  mem_re_a    = 1'b1;
                  mem_raddr_a = par_of_par;
               end
            end
         end
         ST_UP_ROOT: begin
            mem_we = 1'b1;
         end
         ST_DECIDE: begin
            if (!merging_ff) begin
               loaded_in = loaded_inc;
               if (emit) begin
                  merging_in = 1'b1;
               end
            end
            if (emit && (size_ff != '0)) begin
               mem_re_a    = 1'b1;
               mem_raddr_a = '0;
               mem_re_b    = 1'b1;
               mem_raddr_b = size_m1[IW-1:0];
            end
         end
         ST_DONE: begin
            res_valid = 1'b1;
            if (res_ready) begin
               loaded_in  = '0;
               merging_in = 1'b0;
            end
         end
         ST_POP: begin
            res_valid = 1'b1;
            res = '{kind: KIND_ELEMENT,
                    merged_value: {~mem_rdata_a[KEY_W-1], mem_rdata_a[KEY_W-2:LIST_W]},
                    source_list: mem_rdata_a[LIST_W-1:0]};
            if (res_ready) begin
               size_in = size_m1;
               key_in  = mem_rdata_b;
               idx_in  = '0;
               if (pop_more) begin
                  mem_re_a    = 1'b1;
                  mem_raddr_a = IW'(1);
                  mem_re_b    = 1'b1;
                  mem_raddr_b = CW'(2) >= CW'(MAX_LISTS) ? '0 : IW'(2);
               end else if (size_ff == SW'(2)) begin
                  // last entry becomes the root of a one-entry heap
                  mem_we    = 1'b1;
                  mem_waddr = '0;
                  mem_wdata = mem_rdata_b;
               end
            end
         end
         ST_DOWN: begin
            mem_we = 1'b1;
            if (sel_r) begin
               mem_wdata = mem_rdata_b;
            end else if (sel_l) begin
               mem_wdata = mem_rdata_a;
            end
            if (sel_l || sel_r) begin
               idx_in = nidx;
               if (down_more) begin
                  mem_re_a    = 1'b1;
                  mem_raddr_a = nl[IW-1:0];
                  mem_re_b    = 1'b1;
                  mem_raddr_b = nr[IW-1:0];
               end
            end
         end
         ST_DOWN_PLACE: begin
            mem_we = 1'b1;
         end
         default: begin
            in_ready = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         size_ff    <= '0;
         loaded_ff  <= '0;
         merging_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         size_ff    <= size_in;
         loaded_ff  <= loaded_in;
         merging_ff <= merging_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff <= idx_in;
      par_ff <= par_in;
      key_ff <= key_in;
   end

endmodule

>>> rtl/k_way_min_heap_merge_core.sv
// Top level of the k-way min-heap merge core: config, heap sequencer, output register.
//
//  channel | dir | handshake                | payload
//  --------+-----+--------------------------+-------------------------------------------
//  req     | in  | req_tvalid / req_tready  | tdata: list_index, value; tuser: operation
//  rsp     | out | rsp_tvalid / rsp_tready  | tdata: merged_value, source_list; tuser: kind
//  csr     | in  | csr_wr_en                | csr_wr_data: list_count
//
//  One item at a time. A push walks up to log2(MAX_LISTS) levels and a pop walks down
//  the same, one level per step; the walk is set by the single heap memory and its
//  registered reads.
//  Reset clears heap size, load count and phase; list_count returns to 16.
//  A result waits in the output register; a second pop stalls there until it drains.
module k_way_min_heap_merge_core #(
   parameter int MAX_LISTS = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [kwmh_pkg::REQ_DATA_W-1:0]     req_tdata,   // list_index[3:0], value[35:4]
   input  logic                                req_tuser,   // operation
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [kwmh_pkg::RSP_DATA_W-1:0]     rsp_tdata,   // merged_value[31:0], source_list[35:32]
   output logic                                rsp_tuser,   // kind
   input  logic                                csr_wr_en,
   input  logic [kwmh_pkg::COUNT_W-1:0]        csr_wr_data
);
   import kwmh_pkg::*;

   localparam int IW = $clog2(MAX_LISTS);
   localparam int SW = $clog2(MAX_LISTS + 1);

   logic [COUNT_W-1:0] list_count_ff;
   logic               rsp_valid_ff, rsp_valid_in;
   result_type         rsp_ff;

   logic               res_valid;
   logic               res_ready;
   result_type         res;

   logic               mem_we;
   logic [IW-1:0]      mem_waddr;
   key_type            mem_wdata;
   logic               mem_re_a;
   logic [IW-1:0]      mem_raddr_a;
   logic               mem_re_b;
   logic [IW-1:0]      mem_raddr_b;
   key_type            mem_rdata_a;
   key_type            mem_rdata_b;

   always_ff @(posedge clock) begin
      if (reset) begin
         list_count_ff <= LIST_COUNT_RESET;
      end else if (csr_wr_en) begin
         list_count_ff <= csr_wr_data;
      end
   end

   kwmh_sift_ctrl #(
      .MAX_LISTS (MAX_LISTS),
      .IW        (IW),
      .SW        (SW)
   ) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (req_tvalid),
      .in_ready    (req_tready),
      .in_op       (req_tuser),
      .in_list     (req_tdata[LIST_W-1:0]),
      .in_value    (req_tdata[LIST_W+VALUE_W-1:LIST_W]),
      .list_count  (list_count_ff),
      .res_valid   (res_valid),
      .res_ready   (res_ready),
      .res         (res),
      .mem_we      (mem_we),
      .mem_waddr   (mem_waddr),
      .mem_wdata   (mem_wdata),
      .mem_re_a    (mem_re_a),
      .mem_raddr_a (mem_raddr_a),
      .mem_re_b    (mem_re_b),
      .mem_raddr_b (mem_raddr_b),
      .mem_rdata_a (mem_rdata_a),
      .mem_rdata_b (mem_rdata_b)
   );

   kwmh_heap_ram #(
      .DEPTH (MAX_LISTS),
      .AW    (IW)
   ) u_ram (
      .clock   (clock),
      .we      (mem_we),
      .waddr   (mem_waddr),
      .wdata   (mem_wdata),
      .re_a    (mem_re_a),
      .raddr_a (mem_raddr_a),
      .re_b    (mem_re_b),
      .raddr_b (mem_raddr_b),
      .rdata_a (mem_rdata_a),
      .rdata_b (mem_rdata_b)
   );

   assign res_ready = !rsp_valid_ff || rsp_tready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (res_valid && res_ready) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (res_valid && res_ready) begin
         rsp_ff <= res;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_ff.kind;
   assign rsp_tdata  = RSP_DATA_W'({rsp_ff.source_list, rsp_ff.merged_value});

endmodule

>>> rtl/kwmh_checker.sv
// Port-level checks for the k-way min-heap merge core, bound to the top level.
module kwmh_checker (
   input logic                                clock,
   input logic                                reset,
   input logic                                req_tvalid,
   input logic                                req_tready,
   input logic                                rsp_tvalid,
   input logic                                rsp_tready,
   input logic [kwmh_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   input logic                                rsp_tuser
);
   import kwmh_pkg::*;

   a_reset_clears_rsp: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("rsp valid after reset");

   a_one_item_at_a_time: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("item taken on back-to-back cycles");

   a_done_is_empty: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && (rsp_tuser == KIND_DONE)) |-> (rsp_tdata == '0))
      else $error("done item carries payload");

   a_rsp_holds: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> (rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser)))
      else $error("stalled rsp item changed");

endmodule

bind k_way_min_heap_merge_core kwmh_checker u_checker (.*);

>>> bench/k_way_min_heap_merge_core_tb.sv
`timescale 1ns / 100ps
// Testbench for k_way_min_heap_merge_core: directed and random sorted-list merges checked against a merge tracker.
module k_way_min_heap_merge_core_tb;
   import kwmh_pkg::*;

   localparam int       MAX_LISTS       = 16;
   localparam logic     OP_ELEMENT      = ~OP_EXHAUSTED;
   localparam int       QUIET_CYCLES    = 40;
   localparam int       STUCK_LIMIT     = 4000;
   localparam int       HOLD_CYCLES     = 300;
   localparam int       PHASES          = 8;
   localparam int       ITEMS_PER_PHASE = 104;
   localparam int       NOISE_PCT       = 8;
   localparam int       MAX_LIST_LEN    = 4;

   class merge_tracker;
      key_type          heads[$];
      result_type       merged_due[$];
      int unsigned      loaded;
      bit               merging;
      logic [COUNT_W-1:0] list_count;
      int               errors;

      function new();
         loaded     = 0;
         merging    = 0;
         list_count = LIST_COUNT_RESET;
         errors     = 0;
      endfunction

      function void report(string what);
         errors++;
         if (errors <= 20)
            $display("MISMATCH: %s", what);
      endfunction

      function void set_count(logic [COUNT_W-1:0] c);
         list_count = c;
      endfunction

      function int pending();
         return merged_due.size();
      endfunction

      function int unsigned lists_in_run();
         if (list_count == 0)
            return 1;
         if (list_count > MAX_LISTS)
            return MAX_LISTS;
         return list_count;
      endfunction

      // Returns 1 when the item produces a result; r carries it.
      function bit take_item(logic op, logic [LIST_W-1:0] lst, logic [VALUE_W-1:0] val,
                             output result_type r);
         key_type k;
         int      m;
         r = '0;
         if (op != OP_EXHAUSTED && heads.size() < MAX_LISTS)
            heads.push_back({val ^ 32'h8000_0000, lst});
         if (!merging) begin
            loaded++;
            if (loaded < lists_in_run())
               return 0;
            merging = 1;
         end
         if (heads.size() == 0) begin
            r.kind  = KIND_DONE;
            loaded  = 0;
            merging = 0;
         end else begin
            m = 0;
            for (int i = 1; i < heads.size(); i++)
               if (heads[i] < heads[m])
                  m = i;
            k = heads[m];
            heads.delete(m);
            r.kind         = KIND_ELEMENT;
            r.merged_value = k[KEY_W-1:LIST_W] ^ 32'h8000_0000;
            r.source_list  = k[LIST_W-1:0];
         end
         merged_due.push_back(r);
         return 1;
      endfunction

      function void check_output(result_type got);
         result_type want;
         if (merged_due.size() == 0) begin
            report($sformatf("unexpected item kind=%0d value=%0d list=%0d",
                             got.kind, got.merged_value, got.source_list));
            return;
         end
         want = merged_due.pop_front();
         if (got.kind != want.kind || got.merged_value != want.merged_value ||
             got.source_list != want.source_list)
            report($sformatf("got kind=%0d value=%0d list=%0d, want kind=%0d value=%0d list=%0d",
                             got.kind, got.merged_value, got.source_list,
                             want.kind, want.merged_value, want.source_list));
      endfunction
   endclass

   logic                    clock = 1'b0;
   logic                    reset;
   logic                    req_tvalid;
   logic                    req_tready;
   logic [REQ_DATA_W-1:0]   req_tdata;   // list_index[3:0], value[35:4]
   logic                    req_tuser;   // operation
   logic                    rsp_tvalid;
   logic                    rsp_tready;
   logic [RSP_DATA_W-1:0]   rsp_tdata;   // merged_value[31:0], source_list[35:32]
   logic                    rsp_tuser;   // kind
   logic                    csr_wr_en;
   logic [COUNT_W-1:0]      csr_wr_data;

   merge_tracker tracker = new;
   int           list_vals[MAX_LISTS][$];
   int           send_idle_pct;
   int           rsp_stall_pct;
   bit           hold_request;
   int           items_sent;
   int           stuck_cycles;

   k_way_min_heap_merge_core dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         stuck_cycles = 0;
      end else begin
         stuck_cycles++;
         if (stuck_cycles >= STUCK_LIMIT) begin
            $display("k_way_min_heap_merge_core verification failed");
            $finish;
         end
      end
   end

   // result side: check accepted items, stall at random, long hold-off on request
   initial begin
      int         hold_left;
      result_type got;
      hold_left = 0;
      rsp_tready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_tvalid && rsp_tready) begin
            got.kind         = rsp_tuser;
            got.merged_value = rsp_tdata[VALUE_W-1:0];
            got.source_list  = rsp_tdata[VALUE_W+LIST_W-1:VALUE_W];
            tracker.check_output(got);
         end
         if (hold_request) begin
            hold_request = 0;
            hold_left    = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= ($urandom_range(99) >= rsp_stall_pct);
         end
      end
   end

   task automatic send_item(input logic op, input logic [LIST_W-1:0] lst,
                            input logic [VALUE_W-1:0] val, output bit has, output result_type r);
      int gap;
      gap = 0;
      while ($urandom_range(99) < send_idle_pct)
         gap++;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {{(REQ_DATA_W-KEY_W){1'b0}}, val, lst};
      req_tuser  <= op;
      do
         @(posedge clock);
      while (!req_tready);
      has = tracker.take_item(op, lst, val, r);
      items_sent++;
   endtask

   task automatic settle();
      while (tracker.pending() != 0)
         @(posedge clock);
      repeat (QUIET_CYCLES) @(posedge clock);
   endtask

   task automatic write_list_count(input logic [COUNT_W-1:0] c);
      req_tvalid <= 1'b0;
      settle();
      csr_wr_data <= c;
      csr_wr_en   <= 1'b1;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      tracker.set_count(c);
   endtask

   task automatic set_idling(input int mode);
      case (mode)
         0: begin
            send_idle_pct = 0;
            rsp_stall_pct = 0;
         end
         1: begin
            send_idle_pct = 77;
            rsp_stall_pct = 0;
         end
         2: begin
            send_idle_pct = 0;
            rsp_stall_pct = 77;
         end
         default: begin
            send_idle_pct = 36;
            rsp_stall_pct = 36;
         end
      endcase
   endtask

   task automatic fill_lists(input bit wide);
      int n;
      int v;
      int pos;
      for (int l = 0; l < MAX_LISTS; l++) begin
         list_vals[l].delete();
         n = $urandom_range(0, MAX_LIST_LEN);
         repeat (n) begin
            if (!wide)
               v = int'($urandom_range(0, 8)) - 4;
            else if ($urandom_range(0, 9) == 0)
               v = $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
            else
               v = $urandom;
            pos = 0;
            while (pos < list_vals[l].size() && list_vals[l][pos] <= v)
               pos++;
            list_vals[l].insert(pos, v);
         end
      end
   endtask

   // One merge: load heads in list order, then refill from each popped list until done.
   task automatic run_merge(input int noise_pct, input bit mid_write);
      int                li;
      bit                loading;
      bit                finished;
      bit                has;
      logic              op;
      logic [LIST_W-1:0] lst;
      logic [LIST_W-1:0] next_src;
      logic [VALUE_W-1:0] val;
      result_type        r;
      li       = 0;
      loading  = 1;
      finished = 0;
      next_src = '0;
      while (!finished) begin
         lst = loading ? li[LIST_W-1:0] : next_src;
         if (loading)
            li++;
         if ($urandom_range(99) < noise_pct) begin
            op  = 1'($urandom_range(0, 1));
            lst = LIST_W'($urandom_range(0, MAX_LISTS - 1));
            val = $urandom;
         end else if (list_vals[lst].size() != 0) begin
            op  = OP_ELEMENT;
            val = list_vals[lst].pop_front();
         end else begin
            op  = OP_EXHAUSTED;
            val = $urandom;
         end
         send_item(op, lst, val, has, r);
         if (has) begin
            loading = 0;
            if (r.kind == KIND_DONE)
               finished = 1;
            else
               next_src = r.source_list;
         end else if (mid_write && li == 5) begin
            // count changed while heads are still loading
            write_list_count(COUNT_W'($urandom_range(0, 31)));
         end
      end
   endtask

   initial begin
      int                 mode_of[PHASES] = '{0, 1, 2, 3, 1, 2, 3, 0};
      logic [COUNT_W-1:0] cfg_of[PHASES]  = '{5'd3, 5'd16, 5'd0, 5'd31, 5'd1, 5'd9, 5'd2, 5'd16};
      int                 phase_start;
      bit                 first;
      reset         <= 1'b1;
      req_tvalid    <= 1'b0;
      req_tdata     <= '0;
      req_tuser     <= 1'b0;
      csr_wr_en     <= 1'b0;
      csr_wr_data   <= '0;
      send_idle_pct = 0;
      rsp_stall_pct = 0;
      hold_request  = 0;
      items_sent    = 0;
      stuck_cycles  = 0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: all 16 lists at reset count, extremes, equal values, empty lists
      for (int l = 0; l < MAX_LISTS; l++)
         list_vals[l].delete();
      list_vals[1].push_back(32'h7FFF_FFFF);
      list_vals[2].push_back(32'h8000_0000);
      list_vals[2].push_back(32'h7FFF_FFFF);
      list_vals[3].push_back(0);
      list_vals[4].push_back(-1);
      list_vals[5].push_back(0);
      list_vals[15].push_back(32'h5A5A_A5A5);
      run_merge(0, 0);

      for (int p = 0; p < PHASES; p++) begin
         write_list_count(cfg_of[p]);
         set_idling(mode_of[p]);
         if (p == 0)
            hold_request = 1;
         first       = 1;
         phase_start = items_sent;
         while (items_sent - phase_start < ITEMS_PER_PHASE) begin
            fill_lists($urandom_range(0, 1));
            run_merge(NOISE_PCT, p == PHASES - 1 && first);
            first = 0;
         end
      end

      req_tvalid <= 1'b0;
      while (tracker.pending() != 0)
         @(posedge clock);
      repeat (QUIET_CYCLES) @(posedge clock);
      if (tracker.pending() != 0)
         tracker.report($sformatf("%0d results never arrived", tracker.pending()));
      if (tracker.errors == 0)
         $display("k_way_min_heap_merge_core verification clean");
      else
         $display("k_way_min_heap_merge_core verification failed");
      $finish;
   end

endmodule
